// ===== hw/rtl/ili_pkg.sv =====
// Package: sizes, codes and the command word shared by the list cells.
`default_nettype none
package ili_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int POS_W    = $clog2(CAPACITY);
  localparam int IDX_W    = 7;
  localparam int CNT_W    = 7;

  typedef enum logic [2:0] {
    OP_GET       = 3'd0,
    OP_ADD_HEAD  = 3'd1,
    OP_ADD_TAIL  = 3'd2,
    OP_ADD_INDEX = 3'd3,
    OP_DELETE    = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic              ins;
    logic              del;
    logic [IDX_W-1:0]  pos;
    logic [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ili_cell.sv =====
// One list cell: holds an entry and shifts toward head or tail on command.
`default_nettype none
module ili_cell (
  input  wire logic                      clk,
  input  wire ili_pkg::cell_cmd_t        cmd,
  input  wire logic [ili_pkg::POS_W-1:0] my_pos,
  input  wire logic [ili_pkg::DATA_W-1:0] left_in,
  input  wire logic [ili_pkg::DATA_W-1:0] right_in,
  output logic      [ili_pkg::DATA_W-1:0] data_q
);
  import ili_pkg::*;

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;
  logic [IDX_W-1:0]  my_pos_w;
  logic              at_pos;
  logic              past_pos;

  assign my_pos_w = IDX_W'(my_pos);
  assign at_pos   = (my_pos_w == cmd.pos);
  assign past_pos = (my_pos_w > cmd.pos);

  always_comb begin
    data_nxt = data_r;
    if (cmd.ins) begin
      if (at_pos) begin
        data_nxt = cmd.value;
      end else if (past_pos) begin
        data_nxt = left_in;
      end
    end else if (cmd.del) begin
      if (at_pos || past_pos) begin
        data_nxt = right_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule
`default_nettype wire

// ===== hw/rtl/indexed_list_insert_delete.sv =====
// Top level: request decode, entry count, cell chain and result register.
//
//   channel | direction | ports
//   in      | input     | in_valid, in_ready, in_operation, in_index, in_value
//   out     | output    | out_valid, out_ready, out_read_value, out_status,
//           |           | out_entry_count
//
// One request per cycle: every cell shifts at once, and the result is
// registered in the cycle after the transfer. A new request is taken while the
// result register is empty or being emptied in the same cycle. Reset clears
// the count and the result valid; cell contents stay undefined until written.
`default_nettype none
module indexed_list_insert_delete (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [2:0]                  in_operation,
  input  wire logic [ili_pkg::IDX_W-1:0]   in_index,
  input  wire logic signed [ili_pkg::DATA_W-1:0] in_value,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic signed [ili_pkg::DATA_W-1:0] out_read_value,
  output logic [1:0]                       out_status,
  output logic [ili_pkg::CNT_W-1:0]        out_entry_count
);
  import ili_pkg::*;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic                    in_xfer;
  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        count_nxt;
  logic                    full;
  cell_cmd_t               cmd;
  status_t                 status_nxt;
  logic [DATA_W-1:0]       read_nxt;
  logic [DATA_W-1:0]       cell_sel;
  logic [DATA_W-1:0]       cell_q [CAPACITY];
  logic                    out_valid_r;
  logic [DATA_W-1:0]       out_read_value_r;
  status_t                 out_status_r;
  logic [CNT_W-1:0]        out_entry_count_r;

  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;
  assign full     = (count_r >= CAP_CNT);

  always_comb begin
    cell_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (in_index == IDX_W'(i)) begin
        cell_sel = cell_sel | cell_q[i];
      end
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.value  = in_value;
    cmd.pos    = in_index;
    status_nxt = ST_DONE;
    read_nxt   = '0;
    count_nxt  = count_r;
    unique case (in_operation)
      OP_GET: begin
        if (IDX_W'(in_index) < count_r) begin
          read_nxt = cell_sel;
        end else begin
          read_nxt   = '1;
          status_nxt = ST_RANGE;
        end
      end
      OP_ADD_HEAD: begin
        cmd.pos = '0;
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          cmd.ins   = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_ADD_TAIL: begin
        cmd.pos = count_r;
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          cmd.ins   = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_ADD_INDEX: begin
        if (in_index > count_r) begin
          status_nxt = ST_RANGE;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          cmd.ins   = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_DELETE: begin
        if (in_index >= count_r) begin
          status_nxt = ST_RANGE;
        end else begin
          cmd.del   = 1'b1;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
    if (!in_xfer) begin
      cmd.ins   = 1'b0;
      cmd.del   = 1'b0;
      count_nxt = count_r;
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_W-1:0] left_w;
    logic [DATA_W-1:0] right_w;
    if (g == 0) begin : g_head
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_q[g+1];
    end
    ili_cell u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .my_pos   (POS_W'(g)),
      .left_in  (left_w),
      .right_in (right_w),
      .data_q   (cell_q[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (in_xfer) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_read_value_r  <= read_nxt;
      out_status_r      <= status_nxt;
      out_entry_count_r <= count_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_value  = out_read_value_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_entry_count_r;

`ifndef SYNTH
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_CNT)
    else $error("entry count above capacity");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_FULL) |-> out_entry_count_r == CAP_CNT)
    else $error("full status with list not full");

  a_get_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_operation == OP_GET) |=> count_r == $past(count_r))
    else $error("get changed the entry count");

  a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> out_entry_count_r == count_r)
    else $error("reported count differs from held count");
`endif

endmodule
`default_nettype wire
